// ===== rtl/rotation_period_tracker_top_macros.svh =====
// Assertion macros for the rotation period tracker.
// Used by rotation_period_tracker_top; expects i_clk and i_rst_n in scope.
`ifndef ROTATION_PERIOD_TRACKER_TOP_MACROS_SVH
`define ROTATION_PERIOD_TRACKER_TOP_MACROS_SVH

// same-cycle implication
`define RPTRK_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define RPTRK_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/rptrk_pkg.sv =====
// Shared types and constants of the rotation period tracker.
// No dependencies; used by rptrk_div and rotation_period_tracker_top.
`default_nettype none

package rptrk_pkg;

    // 60000000 * 256, numerator of the 24.8 RPM quotient
    localparam logic [33:0] RPM_NUM_Q8 = 34'd15360000000;

    localparam int DEB_W = 20;
    localparam int TMO_W = 24;
    localparam int PPR_W = 5;
    localparam int PAT_W = 12;
    localparam int CFG_W = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PPR      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN  = 2'd3;

    localparam logic [DEB_W-1:0] DEB_RST = 20'd1000;
    localparam logic [TMO_W-1:0] TMO_RST = 24'd2000000;
    localparam logic [PPR_W-1:0] PPR_RST = 5'd1;
    localparam logic [PAT_W-1:0] PAT_RST = 12'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE,
        S_PUSH,
        S_SUM,
        S_AVG,
        S_RPM,
        S_STEP,
        S_CHECK,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/rptrk_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Unsigned DIV_W-bit dividend by 32-bit divisor; uses rptrk_pkg.
`default_nettype none

module rptrk_div
    import rptrk_pkg::*;
#(
    parameter int DIV_W = 35
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [31:0]      i_divisor,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_dvd;   // dividend shifts out the top, quotient in the bottom
    logic [31:0]      r_rem;
    logic [31:0]      r_dsr;

    logic [32:0] trial;
    logic        q_bit;
    logic [31:0] rem_next;

    always_comb begin
        trial    = {r_rem, r_dvd[DIV_W-1]};
        q_bit    = (trial >= {1'b0, r_dsr});
        rem_next = q_bit ? 32'(trial - {1'b0, r_dsr}) : trial[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= rem_next;
            r_dvd <= {r_dvd[DIV_W-2:0], q_bit};
        end else if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

`default_nettype wire

// ===== rtl/rotation_period_tracker_top.sv =====
// Rotation period tracker: edge timing, interval ring and period/RPM/step math.
// Depends on rptrk_pkg, rptrk_div and rotation_period_tracker_top_macros.svh.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------
//   in      | sink      | i_in_valid / o_in_ready   | now_us, edge_req
//   out     | source    | o_out_valid / i_out_ready | signal_valid, average_period_us,
//           |           |                           | rpm_q8, step_interval_us,
//           |           |                           | interval_accepted
//   cfg     | sink      | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// Items without a recompute pass S_EDGE, S_CHECK and S_OUT into the output register; an armed
// edge also passes S_PUSH. A recompute adds the ring sum (S_SUM) and one or two passes of the
// shared divider; a depth that is not a power of two adds a pass.
// One item at a time; input is taken again once the result sits in the output register.
// The output register holds a result until it is transferred; a stall there stalls input.
// Reset is synchronous; the ring needs no clearing pass (the fill count guards reads).
`default_nettype none

module rotation_period_tracker_top
    import rptrk_pkg::*;
#(
    parameter int SAMPLES = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [31:0]          i_now_us,
    input  wire logic                 i_edge_req,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_signal_valid,
    output logic [31:0]               o_average_period_us,
    output logic [31:0]               o_rpm_q8,
    output logic [31:0]               o_step_interval_us,
    output logic                      o_interval_accepted,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

`include "rotation_period_tracker_top_macros.svh"

    localparam int IDX_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int FILL_W = $clog2(SAMPLES + 1);
    localparam int SUM_W  = 32 + $clog2(SAMPLES);
    localparam int DIV_W  = (SUM_W > 34) ? SUM_W : 34;
    localparam bit SAMPLES_POW2 = ((SAMPLES & (SAMPLES - 1)) == 0);
    localparam int AVG_SH = $clog2(SAMPLES);

    // configuration
    logic [DEB_W-1:0] r_debounce;
    logic [TMO_W-1:0] r_timeout;
    logic [PPR_W-1:0] r_ppr;
    logic [PAT_W-1:0] r_pattern;

    // tracking state
    t_state            r_state, n_state;
    logic [31:0]       r_now, n_now;
    logic              r_edge, n_edge;
    logic [31:0]       r_last, n_last;
    logic              r_seen, n_seen;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [31:0]       r_avg, n_avg;
    logic [31:0]       r_rpm, n_rpm;
    logic              r_valid, n_valid;
    logic [31:0]       r_step, n_step;
    logic              r_acc, n_acc;
    logic [31:0]       r_delta, n_delta;
    logic              r_pass, n_pass;
    logic [FILL_W-1:0] r_cnt, n_cnt;
    logic              r_rd_vld, n_rd_vld;
    logic [SUM_W-1:0]  r_sum, n_sum;

    // output register
    logic              r_out_valid, n_out_valid;
    logic              r_out_sig, n_out_sig;
    logic [31:0]       r_out_avg, n_out_avg;
    logic [31:0]       r_out_rpm, n_out_rpm;
    logic [31:0]       r_out_step, n_out_step;
    logic              r_out_acc, n_out_acc;

    // ring memory
    logic [31:0]      r_ring [0:SAMPLES-1];
    logic [31:0]      r_rd_data;
    logic             ring_we;
    logic [31:0]      ring_wdata;
    logic [IDX_W-1:0] rd_addr;

    // divider
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [31:0]      div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_q;

    logic [36:0] prod;
    logic [31:0] rot;
    logic [31:0] elapsed;
    logic [31:0] sum_avg;

    rptrk_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign rd_addr = r_cnt[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_idx] <= ring_wdata;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEB_RST;
            r_timeout  <= TMO_RST;
            r_ppr      <= PPR_RST;
            r_pattern  <= PAT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data[DEB_W-1:0];
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[TMO_W-1:0];
                CFG_PPR:      r_ppr      <= i_cfg_data[PPR_W-1:0];
                CFG_PATTERN:  r_pattern  <= i_cfg_data[PAT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_seen      <= 1'b0;
            r_idx       <= '0;
            r_fill      <= '0;
            r_avg       <= '0;
            r_rpm       <= '0;
            r_valid     <= 1'b0;
            r_step      <= '0;
            r_acc       <= 1'b0;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_seen      <= n_seen;
            r_idx       <= n_idx;
            r_fill      <= n_fill;
            r_avg       <= n_avg;
            r_rpm       <= n_rpm;
            r_valid     <= n_valid;
            r_step      <= n_step;
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_edge     <= n_edge;
        r_delta    <= n_delta;
        r_pass     <= n_pass;
        r_sum      <= n_sum;
        r_out_sig  <= n_out_sig;
        r_out_avg  <= n_out_avg;
        r_out_rpm  <= n_out_rpm;
        r_out_step <= n_out_step;
        r_out_acc  <= n_out_acc;
    end

    always_comb begin
        n_state      = r_state;
        n_now        = r_now;
        n_edge       = r_edge;
        n_last       = r_last;
        n_seen       = r_seen;
        n_idx        = r_idx;
        n_fill       = r_fill;
        n_avg        = r_avg;
        n_rpm        = r_rpm;
        n_valid      = r_valid;
        n_step       = r_step;
        n_acc        = r_acc;
        n_delta      = r_delta;
        n_pass       = r_pass;
        n_cnt        = r_cnt;
        n_rd_vld     = 1'b0;
        n_sum        = r_sum;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_sig    = r_out_sig;
        n_out_avg    = r_out_avg;
        n_out_rpm    = r_out_rpm;
        n_out_step   = r_out_step;
        n_out_acc    = r_out_acc;
        ring_we      = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(r_sum);
        div_divisor  = 32'(SAMPLES);
        o_in_ready   = (r_state == S_IDLE);

        prod    = 37'(r_delta) * 37'(r_ppr);
        rot     = (prod[36:32] != '0) ? 32'hFFFF_FFFF : prod[31:0];
        ring_wdata = rot;
        elapsed = r_now - r_last;
        sum_avg = 32'(r_sum >> AVG_SH);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_now   = i_now_us;
                    n_edge  = i_edge_req;
                    n_acc   = 1'b0;
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                n_delta = r_now - r_last;
                n_pass  = (n_delta >= 32'(r_debounce));
                if (!r_edge) begin
                    n_state = S_CHECK;
                end else if (!r_seen) begin
                    n_seen  = 1'b1;
                    n_last  = r_now;
                    n_state = S_CHECK;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                n_state = S_CHECK;
                if (r_pass) begin
                    n_last = r_now;
                    if (rot != '0) begin
                        ring_we = 1'b1;
                        n_acc   = 1'b1;
                        n_idx   = (r_idx == IDX_W'(SAMPLES - 1)) ? '0 : r_idx + IDX_W'(1);
                        if (r_fill != FILL_W'(SAMPLES)) begin
                            n_fill = r_fill + FILL_W'(1);
                        end
                        if (n_fill == FILL_W'(SAMPLES)) begin
                            n_cnt   = '0;
                            n_sum   = '0;
                            n_state = S_SUM;
                        end
                    end
                end
            end
            S_SUM: begin
                // one read issued per cycle, data lands in the next cycle
                if (r_cnt != FILL_W'(SAMPLES)) begin
                    n_cnt    = r_cnt + FILL_W'(1);
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    n_sum = r_sum + SUM_W'(r_rd_data);
                end
                if (r_cnt == FILL_W'(SAMPLES) && !r_rd_vld) begin
                    div_start = 1'b1;
                    if (SAMPLES_POW2) begin
                        // power-of-two depth: the average is a shift, go on to the RPM
                        n_avg        = sum_avg;
                        div_dividend = DIV_W'(RPM_NUM_Q8);
                        div_divisor  = sum_avg;
                        n_state      = S_RPM;
                    end else begin
                        n_state = S_AVG;
                    end
                end
            end
            S_AVG: begin
                if (div_done) begin
                    n_avg        = div_q[31:0];
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(RPM_NUM_Q8);
                    div_divisor  = div_q[31:0];
                    n_state      = S_RPM;
                end
            end
            S_RPM: begin
                if (div_done) begin
                    // a zero divisor yields all ones, which saturates as well
                    n_rpm   = (div_q[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
                    n_valid = 1'b1;
                    if (r_pattern != '0) begin
                        div_start    = 1'b1;
                        div_dividend = DIV_W'(r_avg);
                        div_divisor  = 32'(r_pattern);
                        n_state      = S_STEP;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_STEP: begin
                if (div_done) begin
                    n_step  = (div_q[31:0] == '0) ? 32'd1 : div_q[31:0];
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_seen && (elapsed > 32'(r_timeout))) begin
                    n_seen  = 1'b0;
                    n_last  = '0;
                    n_idx   = '0;
                    n_fill  = '0;
                    n_avg   = '0;
                    n_rpm   = '0;
                    n_valid = 1'b0;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_sig   = r_valid;
                    n_out_avg   = r_avg;
                    n_out_rpm   = r_rpm;
                    n_out_step  = r_step;
                    n_out_acc   = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid         = r_out_valid;
    assign o_signal_valid      = r_out_sig;
    assign o_average_period_us = r_out_avg;
    assign o_rpm_q8            = r_out_rpm;
    assign o_step_interval_us  = r_out_step;
    assign o_interval_accepted = r_out_acc;

    `RPTRK_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= FILL_W'(SAMPLES), "ring fill above depth")
    `RPTRK_ASSERT_NOW(a_valid_full, r_valid, r_fill == FILL_W'(SAMPLES), "valid without full ring")
    `RPTRK_ASSERT_NOW(a_valid_avg, r_valid, r_avg != '0, "valid with zero average")
    `RPTRK_ASSERT_NEXT(a_busy_after, i_in_valid && o_in_ready, r_state != S_IDLE,
        "transfer did not start work")

endmodule

`default_nettype wire

// ===== sim/rotation_period_tracker_checker.sv =====
`timescale 1ns / 1ps
// Result checker for rotation_period_tracker_top: tracks config writes, predicts one
// reading per input transfer from its own copy of the tracker state, compares output transfers.
// Depends on rptrk_pkg for the register indexes and port widths.

module rotation_period_tracker_checker
    import rptrk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [31:0]          i_now_us,
    input  logic                 i_edge_req,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_signal_valid,
    input  logic [31:0]          i_average_period_us,
    input  logic [31:0]          i_rpm_q8,
    input  logic [31:0]          i_step_interval_us,
    input  logic                 i_interval_accepted,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic        signal_valid;
        logic [31:0] average_period_us;
        logic [31:0] rpm_q8;
        logic [31:0] step_interval_us;
        logic        interval_accepted;
    } tach_reading_t;

    localparam int          RING_DEPTH   = 8;
    localparam logic [63:0] RPM_SCALE_Q8 = 64'd15360000000;  // 60e6 minutes-to-us, times 256

    logic [19:0] debounce_cfg;
    logic [23:0] timeout_cfg;
    logic [4:0]  ppr_cfg;
    logic [11:0] pattern_cfg;

    logic [31:0] last_edge_us;
    bit          edge_armed;
    logic [31:0] interval_ring [RING_DEPTH];
    int          ring_wr;
    int          ring_count;
    logic [31:0] avg_period;
    logic [31:0] rpm_q8;
    logic [31:0] step_us;
    bit          reading_valid;

    tach_reading_t expected_readings [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // step_us survives a timeout, only a reset clears it
    function automatic void clear_tracking();
        foreach (interval_ring[k]) interval_ring[k] = '0;
        ring_wr       = 0;
        ring_count    = 0;
        avg_period    = '0;
        rpm_q8        = '0;
        reading_valid = 1'b0;
        edge_armed    = 1'b0;
        last_edge_us  = '0;
    endfunction

    function automatic tach_reading_t track_sample(input logic [31:0] now, input logic is_edge);
        logic [31:0]   delta;
        logic [63:0]   prod;
        logic [63:0]   total;
        logic [63:0]   quo;
        logic [31:0]   rot;
        bit            took;
        tach_reading_t res;
        took = 1'b0;
        if (is_edge) begin
            if (!edge_armed) begin
                edge_armed   = 1'b1;
                last_edge_us = now;
            end else begin
                delta = now - last_edge_us;
                if (delta >= 32'(debounce_cfg)) begin
                    prod = 64'(delta) * 64'(ppr_cfg);
                    rot  = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
                    last_edge_us = now;
                    if (rot != 0) begin
                        took = 1'b1;
                        interval_ring[ring_wr] = rot;
                        ring_wr = (ring_wr == RING_DEPTH - 1) ? 0 : ring_wr + 1;
                        if (ring_count < RING_DEPTH) ring_count++;
                        if (ring_count == RING_DEPTH) begin
                            total = '0;
                            foreach (interval_ring[k]) total += 64'(interval_ring[k]);
                            avg_period = 32'(total / 64'(RING_DEPTH));
                            if (avg_period == 0) begin
                                rpm_q8 = 32'hFFFF_FFFF;
                            end else begin
                                quo    = RPM_SCALE_Q8 / 64'(avg_period);
                                rpm_q8 = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
                            end
                            reading_valid = 1'b1;
                            if (pattern_cfg != 0) begin
                                step_us = avg_period / 32'(pattern_cfg);
                                if (step_us == 0) step_us = 32'd1;
                            end
                        end
                    end
                end
            end
        end
        delta = now - last_edge_us;
        if (edge_armed && delta > 32'(timeout_cfg)) clear_tracking();
        res.signal_valid      = reading_valid;
        res.average_period_us = avg_period;
        res.rpm_q8            = rpm_q8;
        res.step_interval_us  = step_us;
        res.interval_accepted = took;
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        tach_reading_t exp_r;
        if (!i_rst_n) begin
            debounce_cfg = 20'd1000;
            timeout_cfg  = 24'd2000000;
            ppr_cfg      = 5'd1;
            pattern_cfg  = 12'd0;
            step_us      = '0;
            clear_tracking();
            expected_readings.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: result transfer with nothing pending: valid=%0d avg=0x%0h",
                             $time, i_signal_valid, i_average_period_us);
                    o_fail_count++;
                end else begin
                    exp_r = expected_readings.pop_front();
                    compare_field("signal_valid", 32'(exp_r.signal_valid), 32'(i_signal_valid));
                    compare_field("average_period_us", exp_r.average_period_us,
                                  i_average_period_us);
                    compare_field("rpm_q8", exp_r.rpm_q8, i_rpm_q8);
                    compare_field("step_interval_us", exp_r.step_interval_us, i_step_interval_us);
                    compare_field("interval_accepted", 32'(exp_r.interval_accepted),
                                  32'(i_interval_accepted));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_readings.push_back(track_sample(i_now_us, i_edge_req));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEBOUNCE: debounce_cfg = i_cfg_data[19:0];
                    CFG_TIMEOUT:  timeout_cfg  = i_cfg_data[23:0];
                    CFG_PPR:      ppr_cfg      = i_cfg_data[4:0];
                    CFG_PATTERN:  pattern_cfg  = i_cfg_data[11:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_readings.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the rotation period tracker testbench: clock, reset, config phases, directed and
// random edge/timestamp stimulus, receiver stalls, watchdog and verdict.
// Depends on rptrk_pkg, rotation_period_tracker_top and rotation_period_tracker_checker.

module testbench;
    import rptrk_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int DRAIN_CYCLES = 200;

    typedef enum int {RX_STREAM, RX_COIN, RX_STALLS} rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [31:0]          now_us;
    logic                 edge_req;
    logic                 out_valid;
    logic                 out_ready;
    logic                 signal_valid;
    logic [31:0]          average_period_us;
    logic [31:0]          rpm_q8;
    logic [31:0]          step_interval_us;
    logic                 interval_accepted;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    int          fail_count;
    int          pending;
    int          burst_left = 0;
    int          items_sent = 0;
    int          stall_cycles;
    rx_mode_t    rx_mode    = RX_STREAM;
    int          mode_left  = 0;
    int          stall_left = 0;
    logic [31:0] gen_edge_us;

    always #5 clk = ~clk;

    rotation_period_tracker_top dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_now_us            (now_us),
        .i_edge_req          (edge_req),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_signal_valid      (signal_valid),
        .o_average_period_us (average_period_us),
        .o_rpm_q8            (rpm_q8),
        .o_step_interval_us  (step_interval_us),
        .o_interval_accepted (interval_accepted),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data)
    );

    rotation_period_tracker_checker period_check (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_ready          (in_ready),
        .i_now_us            (now_us),
        .i_edge_req          (edge_req),
        .i_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .i_signal_valid      (signal_valid),
        .i_average_period_us (average_period_us),
        .i_rpm_q8            (rpm_q8),
        .i_step_interval_us  (step_interval_us),
        .i_interval_accepted (interval_accepted),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // receiver: always ready, coin flips, or mostly ready with long stalls
    always @(negedge clk) begin
        if (mode_left == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(32, 256);
        end else begin
            mode_left--;
        end
        if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STREAM: out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                default: begin
                    if ($urandom_range(0, 9) == 0) begin
                        stall_left = $urandom_range(1, 40);
                        out_ready <= 1'b0;
                    end else begin
                        out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // starts and ends just after a falling edge
    task automatic send_sample(input logic [31:0] t_us, input logic is_edge);
        int gap;
        in_valid <= 1'b1;
        now_us   <= t_us;
        edge_req <= is_edge;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 160);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 30);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    task automatic load_config(input int unsigned deb, input int unsigned tmo,
                               input int unsigned ppr, input int unsigned pat);
        wait_idle();
        write_reg(CFG_DEBOUNCE, CFG_W'(deb));
        write_reg(CFG_TIMEOUT, CFG_W'(tmo));
        write_reg(CFG_PPR, CFG_W'(ppr));
        write_reg(CFG_PATTERN, CFG_W'(pat));
        cfg_we <= 1'b0;
    endtask

    // one config setting, then edges around a nominal period with noise samples,
    // bounces, timeouts and wild jumps mixed in
    task automatic random_phase();
        int unsigned period, deb, tmo, ppr, pat, span, r, deb_top;
        int          n;
        r = $urandom_range(0, 9);
        if (r < 2)      period = $urandom_range(1, 8);
        else if (r < 7) period = $urandom_range(500, 60000);
        else if (r < 9) period = $urandom_range(60000, 5000000);
        else            period = $urandom_range(5000000, 32'h7FFF_FFFF);

        deb_top = period - period / 4;
        if (deb_top > 20'hFFFFF) deb_top = 20'hFFFFF;
        r = $urandom_range(0, 19);
        if (r < 14)      deb = $urandom_range(0, deb_top);
        else if (r < 17) deb = 0;
        else if (r < 19) deb = 20'hFFFFF;
        else             deb = $urandom_range(0, 20'hFFFFF);

        r = $urandom_range(0, 19);
        if (r < 14)      tmo = (period >= 8000000) ? 24'hFFFFFF
                                                   : 2 * period + $urandom_range(0, 1000);
        else if (r < 17) tmo = 24'hFFFFFF;
        else if (r < 19) tmo = $urandom_range(0, 24'hFFFFFF);
        else             tmo = 0;

        ppr = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 16);

        r = $urandom_range(0, 9);
        if (r < 2)      pat = 0;
        else if (r < 3) pat = 12'hFFF;
        else if (r < 6) pat = $urandom_range(1, 8);
        else            pat = $urandom_range(1, 12'hFFF);

        load_config(deb, tmo, ppr, pat);
        gen_edge_us = $urandom;
        n = $urandom_range(40, 120);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                span = period - period / 8 + $urandom_range(0, period / 4);
                gen_edge_us += span;
                send_sample(gen_edge_us, 1'b1);
            end else if (r < 85) begin
                send_sample(gen_edge_us + $urandom_range(0, period), 1'b0);
            end else if (r < 93) begin
                send_sample(gen_edge_us + $urandom_range(0, deb), 1'b1);
            end else if (r < 97) begin
                gen_edge_us += tmo + $urandom_range(1, 10);
                send_sample(gen_edge_us, 1'b0);
            end else begin
                gen_edge_us = $urandom;
                send_sample(gen_edge_us, 1'b1);
            end
            items_sent++;
        end
    endtask

    // watchdog: too long without any transfer on either channel
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int k;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        now_us    = '0;
        edge_req  = 1'b0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset config: first edge, bounce, edge at exactly the debounce time,
        // idle at exactly the timeout, then one past it
        send_sample(32'd0, 1'b0);
        send_sample(32'd0, 1'b1);
        send_sample(32'd999, 1'b1);
        send_sample(32'd1000, 1'b1);
        send_sample(32'd2001000, 1'b0);
        send_sample(32'd2001001, 1'b0);

        // tiny intervals across the 2^32 wrap: rpm saturates, step floors to 1
        load_config(0, 24'hFFFFFF, 1, 12'hFFF);
        send_sample(32'hFFFF_FFFC, 1'b1);
        for (k = 1; k <= 8; k++) send_sample(32'hFFFF_FFFC + k, 1'b1);
        send_sample(32'd4, 1'b1);  // zero delta with no debounce: nothing enters the ring

        // product overflow, zero timeout, step held with zero pattern, bounce then clear
        load_config(20'hFFFFF, 0, 16, 0);
        send_sample(32'h2000_0004, 1'b1);
        send_sample(32'h2000_0004, 1'b0);
        send_sample(32'h2000_0009, 1'b1);

        // zero pulses per rev: edge time moves, ring untouched
        load_config(0, 100, 0, 1);
        send_sample(32'h5555_0000, 1'b1);
        send_sample(32'h5555_0032, 1'b1);

        while (items_sent < RANDOM_ITEMS) random_phase();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
